// ===== design/trpl_pkg.sv =====
// shared types and constants of the typed priority ready list
package trpl_pkg;

	localparam int INSTR_W   = 8;
	localparam int PRIO_W    = 8;
	localparam int TYPE_W    = 2;
	localparam int MASK_W    = 4;
	localparam int NUM_TYPES = 4;
	localparam int CMD_W     = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_TAKE   = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef logic [TYPE_W-1:0] utype_t;

	localparam utype_t UT0 = 2'd0;
	localparam utype_t UT1 = 2'd1;
	localparam utype_t UT2 = 2'd2;
	localparam utype_t UT3 = 2'd3;

	// priority bit that selects head insertion in binary mode
	localparam int PRIO_HEAD_BIT = PRIO_W - 1;

	// free ring controls
	typedef struct packed {
		logic pop;
		logic push;
		logic clear;
	} ring_ctl_t;

	// slot store controls
	typedef struct packed {
		logic re;
		logic we_instr;
		logic we_link;
	} slot_ctl_t;

endpackage

// ===== design/trpl_channels.sv =====
// valid/ready channels for requests and responses
interface trpl_req_if import trpl_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [INSTR_W-1:0] instr_number;
	logic [TYPE_W-1:0]  instr_type;
	logic [PRIO_W-1:0]  priority_req;
	logic [MASK_W-1:0]  unit_mask;

	modport source (output valid, command, instr_number, instr_type, priority_req, unit_mask,
		input ready);
	modport sink (input valid, command, instr_number, instr_type, priority_req, unit_mask,
		output ready);
endinterface

interface trpl_rsp_if import trpl_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               full_flag;
	logic               found;
	logic [INSTR_W-1:0] taken_number;

	modport source (output valid, full_flag, found, taken_number, input ready);
	modport sink (input valid, full_flag, found, taken_number, output ready);
endinterface

// ===== design/typed_priority_ready_list_core.sv =====
// typed priority ready list: four linked lists over a slot pool, sequencer on top
// flow: clear and refused insert finish on accept; take reads the head, then finishes;
//   empty-list and head insert finish on placement, binary tail insert then links the old tail,
//   sorted insert past the head walks the links, then links; throughput: one request at a time;
//   one slot store read or write per cycle sets the walk rate of one link per cycle
// reset: lists empty, free ring identity via fill bits, sorted_mode 0, no sweep
module typed_priority_ready_list_core import trpl_pkg::*; #(
	parameter int POOL_SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	trpl_req_if.sink    req,
	trpl_rsp_if.source  rsp
);

	localparam int IDX_W = $clog2(POOL_SLOTS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PLACE,
		S_WALK,
		S_LINK,
		S_TAKE,
		S_HOLD
	} state_t;

	state_t state_q;

	// list registers, one entry per unit type
	logic [IDX_W-1:0]  head_q  [NUM_TYPES];
	logic [IDX_W-1:0]  tail_q  [NUM_TYPES];
	logic [PRIO_W-1:0] hprio_q [NUM_TYPES];
	logic [IDX_W-1:0]  count_q [NUM_TYPES];
	logic              sorted_q;

	// held request and walk state
	logic [INSTR_W-1:0] num_q;
	logic [PRIO_W-1:0]  prio_q;
	utype_t             type_q;
	logic [IDX_W-1:0]   place_q, cur_q, link_addr_q, steps_q;

	// response register and the pending result when it is occupied
	logic               rsp_valid_q, rsp_full_q, rsp_found_q;
	logic [INSTR_W-1:0] rsp_taken_q;
	logic               hold_full_q, hold_found_q;
	logic [INSTR_W-1:0] hold_taken_q;

	// memory ports
	ring_ctl_t          ring_ctl;
	logic [IDX_W-1:0]   ring_place;
	logic               ring_full;
	slot_ctl_t          slot_ctl;
	logic [IDX_W-1:0]   slot_waddr, slot_raddr, slot_wnext;
	logic [INSTR_W-1:0] slot_winstr, slot_rinstr;
	logic [PRIO_W-1:0]  slot_wprio, slot_rprio;
	logic [IDX_W-1:0]   slot_rnext;

	logic   accept, rsp_free, rsp_load;
	cmd_t   req_cmd;
	utype_t c1, c2, take_sel;
	logic   take_ok;
	logic   cur_empty, head_ins, walk_last, walk_on;

	// finishing result of this cycle
	logic               fin, fin_full, fin_found;
	logic [INSTR_W-1:0] fin_taken;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign rsp_free  = !rsp_valid_q || rsp.ready;
	// response register takes a new result this cycle
	assign rsp_load  = rsp_free && (fin || state_q == S_HOLD);
	assign req_cmd   = cmd_t'(req.command);

	assign rsp.valid        = rsp_valid_q;
	assign rsp.full_flag    = rsp_full_q;
	assign rsp.found        = rsp_found_q;
	assign rsp.taken_number = rsp_taken_q;

	// take choice from the capability mask: first choice, second choice, then type two
	always_comb begin
		if (req.unit_mask[0]) begin
			c1 = UT0;
		end else if (req.unit_mask[1]) begin
			c1 = UT1;
		end else if (req.unit_mask[3]) begin
			c1 = UT3;
		end else begin
			c1 = UT2;
		end
		c2 = (req.unit_mask[1] && req.unit_mask[3]) ? UT3 : UT2;
		take_ok  = 1'b1;
		take_sel = UT2;
		if (req.unit_mask == '0) begin
			take_ok = 1'b0;
		end else if (count_q[c1] != '0) begin
			take_sel = c1;
		end else if (count_q[c2] != '0) begin
			take_sel = c2;
		end else if (count_q[UT2] == '0) begin
			take_ok = 1'b0;
		end
	end

	// insert decisions on the held request
	assign cur_empty = (count_q[type_q] == '0);
	assign head_ins  = sorted_q ? (prio_q >= hprio_q[type_q]) : prio_q[PRIO_HEAD_BIT];
	assign walk_last = ({1'b0, steps_q} + 1'b1) >= {1'b0, count_q[type_q]};
	assign walk_on   = !walk_last && (slot_rprio > prio_q);

	// memory controls and the finishing result
	always_comb begin
		ring_ctl    = '0;
		slot_ctl    = '0;
		slot_waddr  = place_q;
		slot_winstr = num_q;
		slot_wnext  = place_q;
		slot_wprio  = '0;
		slot_raddr  = head_q[type_q];
		fin         = 1'b0;
		fin_full    = 1'b0;
		fin_found   = 1'b0;
		fin_taken   = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req_cmd)
						CMD_INSERT: begin
							if (ring_full) begin
								fin      = 1'b1;
								fin_full = 1'b1;
							end else begin
								ring_ctl.pop = 1'b1;
							end
						end
						CMD_TAKE: begin
							if (take_ok) begin
								slot_ctl.re = 1'b1;
								slot_raddr  = head_q[take_sel];
							end else begin
								fin = 1'b1;
							end
						end
						CMD_CLEAR: begin
							ring_ctl.clear = 1'b1;
							fin            = 1'b1;
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			S_PLACE: begin
				slot_waddr = ring_place;
				slot_wnext = ring_place;
				if (cur_empty) begin
					slot_ctl.we_instr = 1'b1;
					slot_ctl.we_link  = 1'b1;
					fin               = 1'b1;
				end else if (head_ins) begin
					slot_ctl.we_instr = 1'b1;
					slot_ctl.we_link  = 1'b1;
					slot_wnext        = head_q[type_q];
					slot_wprio        = hprio_q[type_q];
					fin               = 1'b1;
				end else if (!sorted_q) begin
					// new tail, old tail patched next cycle
					slot_ctl.we_instr = 1'b1;
					slot_ctl.we_link  = 1'b1;
				end else begin
					slot_ctl.re = 1'b1;
				end
			end
			S_WALK: begin
				if (walk_last) begin
					slot_ctl.we_instr = 1'b1;
					slot_ctl.we_link  = 1'b1;
				end else if (walk_on) begin
					slot_ctl.re = 1'b1;
					slot_raddr  = slot_rnext;
				end else begin
					// splice in front of the current successor
					slot_ctl.we_instr = 1'b1;
					slot_ctl.we_link  = 1'b1;
					slot_wnext        = slot_rnext;
					slot_wprio        = slot_rprio;
				end
			end
			S_LINK: begin
				slot_ctl.we_link = 1'b1;
				slot_waddr       = link_addr_q;
				slot_wnext       = place_q;
				slot_wprio       = prio_q;
				fin              = 1'b1;
			end
			S_TAKE: begin
				ring_ctl.push = 1'b1;
				fin           = 1'b1;
				fin_found     = 1'b1;
				fin_taken     = slot_rinstr;
			end
			default: begin
			end
		endcase
	end

	// sequencer, list registers and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			sorted_q     <= 1'b0;
			rsp_valid_q  <= 1'b0;
			rsp_full_q   <= 1'b0;
			rsp_found_q  <= 1'b0;
			rsp_taken_q  <= '0;
			hold_full_q  <= 1'b0;
			hold_found_q <= 1'b0;
			hold_taken_q <= '0;
			num_q        <= '0;
			prio_q       <= '0;
			type_q       <= UT0;
			place_q      <= '0;
			cur_q        <= '0;
			link_addr_q  <= '0;
			steps_q      <= '0;
			for (int i = 0; i < NUM_TYPES; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				hprio_q[i] <= '0;
				count_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				sorted_q <= cfg_wdata;
			end
			if (rsp_valid_q && rsp.ready && !rsp_load) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						num_q  <= req.instr_number;
						prio_q <= req.priority_req;
						type_q <= (req_cmd == CMD_TAKE) ? take_sel : req.instr_type;
						case (req_cmd)
							CMD_INSERT: begin
								if (!ring_full) begin
									state_q <= S_PLACE;
								end
							end
							CMD_TAKE: begin
								if (take_ok) begin
									state_q <= S_TAKE;
								end
							end
							CMD_CLEAR: begin
								for (int i = 0; i < NUM_TYPES; i++) begin
									head_q[i]  <= '0;
									tail_q[i]  <= '0;
									hprio_q[i] <= '0;
									count_q[i] <= '0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_PLACE: begin
					place_q <= ring_place;
					if (cur_empty) begin
						head_q[type_q]  <= ring_place;
						tail_q[type_q]  <= ring_place;
						hprio_q[type_q] <= prio_q;
						count_q[type_q] <= count_q[type_q] + 1'b1;
					end else if (head_ins) begin
						head_q[type_q]  <= ring_place;
						hprio_q[type_q] <= prio_q;
						count_q[type_q] <= count_q[type_q] + 1'b1;
					end else if (!sorted_q) begin
						tail_q[type_q] <= ring_place;
						link_addr_q    <= tail_q[type_q];
						state_q        <= S_LINK;
					end else begin
						cur_q   <= head_q[type_q];
						steps_q <= '0;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (walk_last) begin
						tail_q[type_q] <= place_q;
						link_addr_q    <= cur_q;
						state_q        <= S_LINK;
					end else if (walk_on) begin
						cur_q   <= slot_rnext;
						steps_q <= steps_q + 1'b1;
					end else begin
						link_addr_q <= cur_q;
						state_q     <= S_LINK;
					end
				end
				S_LINK: begin
					count_q[type_q] <= count_q[type_q] + 1'b1;
				end
				S_TAKE: begin
					head_q[type_q]  <= slot_rnext;
					hprio_q[type_q] <= slot_rprio;
					count_q[type_q] <= count_q[type_q] - 1'b1;
				end
				S_HOLD: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						rsp_full_q  <= hold_full_q;
						rsp_found_q <= hold_found_q;
						rsp_taken_q <= hold_taken_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// a finished request goes out now, or waits in the hold register
			if (fin) begin
				if (rsp_free) begin
					rsp_valid_q <= 1'b1;
					rsp_full_q  <= fin_full;
					rsp_found_q <= fin_found;
					rsp_taken_q <= fin_taken;
					state_q     <= S_IDLE;
				end else begin
					hold_full_q  <= fin_full;
					hold_found_q <= fin_found;
					hold_taken_q <= fin_taken;
					state_q      <= S_HOLD;
				end
			end
		end
	end

	trpl_ring #(
		.POOL_SLOTS(POOL_SLOTS)
	) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ring_ctl),
		.push_data(head_q[type_q]),
		.pop_data (ring_place),
		.full     (ring_full)
	);

	trpl_slot_mem #(
		.POOL_SLOTS(POOL_SLOTS)
	) u_slot_mem (
		.clk     (clk),
		.ctl     (slot_ctl),
		.waddr   (slot_waddr),
		.wr_instr(slot_winstr),
		.wr_next (slot_wnext),
		.wr_prio (slot_wprio),
		.raddr   (slot_raddr),
		.rd_instr(slot_rinstr),
		.rd_next (slot_rnext),
		.rd_prio (slot_rprio)
	);

	// occupancy of the lists agrees with the ring when it reports full
	logic [IDX_W+1:0] count_sum;
	assign count_sum = (IDX_W+2)'(count_q[0]) + (IDX_W+2)'(count_q[1])
		+ (IDX_W+2)'(count_q[2]) + (IDX_W+2)'(count_q[3]);

	a_full_matches_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && ring_full) |-> (count_sum == (IDX_W+2)'(POOL_SLOTS - 1)))
		else $error("ring full while lists hold a different number of slots");

	a_no_full_and_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_full_q && rsp_found_q))
		else $error("response flags both full and found");

	a_walk_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (steps_q < count_q[type_q]))
		else $error("list walk ran past the list length");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_cmd == CMD_CLEAR) |=>
		(count_q[0] == '0 && count_q[1] == '0 && count_q[2] == '0 && count_q[3] == '0))
		else $error("lists not empty after clear");

endmodule

// ===== design/trpl_ring.sv =====
// free slot ring: memory with identity fill bits, take and return pointers
module trpl_ring import trpl_pkg::*; #(
	parameter int POOL_SLOTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ring_ctl_t                     ctl,
	input  logic [$clog2(POOL_SLOTS)-1:0] push_data,
	output logic [$clog2(POOL_SLOTS)-1:0] pop_data,
	output logic                          full
);

	localparam int IDX_W = $clog2(POOL_SLOTS);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(POOL_SLOTS - 1);

	logic [IDX_W-1:0] ring_mem [POOL_SLOTS];
	logic [POOL_SLOTS-1:0] written_q;
	logic [IDX_W-1:0] take_q, ret_q, take_nxt, ret_nxt;
	logic [IDX_W-1:0] rd_data_q, rd_addr_q;
	logic             rd_hit_q;

	assign take_nxt = (take_q == LAST) ? '0 : take_q + 1'b1;
	assign ret_nxt  = (ret_q == LAST) ? '0 : ret_q + 1'b1;
	assign full     = (take_nxt == ret_q);

	// an entry never written since clear holds its own index
	assign pop_data = rd_hit_q ? rd_data_q : rd_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			take_q    <= '0;
			ret_q     <= '0;
			written_q <= '0;
		end else if (ctl.clear) begin
			take_q    <= '0;
			ret_q     <= '0;
			written_q <= '0;
		end else begin
			if (ctl.pop) begin
				take_q <= take_nxt;
			end
			if (ctl.push) begin
				ret_q            <= ret_nxt;
				written_q[ret_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			ring_mem[ret_q] <= push_data;
		end
		if (ctl.pop) begin
			rd_data_q <= ring_mem[take_q];
			rd_hit_q  <= written_q[take_q];
			rd_addr_q <= take_q;
		end
	end

endmodule

// ===== design/trpl_slot_mem.sv =====
// slot store: instruction number, successor link and successor priority per slot
module trpl_slot_mem import trpl_pkg::*; #(
	parameter int POOL_SLOTS = 64
) (
	input  logic                          clk,
	input  slot_ctl_t                     ctl,
	input  logic [$clog2(POOL_SLOTS)-1:0] waddr,
	input  logic [INSTR_W-1:0]            wr_instr,
	input  logic [$clog2(POOL_SLOTS)-1:0] wr_next,
	input  logic [PRIO_W-1:0]             wr_prio,
	input  logic [$clog2(POOL_SLOTS)-1:0] raddr,
	output logic [INSTR_W-1:0]            rd_instr,
	output logic [$clog2(POOL_SLOTS)-1:0] rd_next,
	output logic [PRIO_W-1:0]             rd_prio
);

	localparam int IDX_W = $clog2(POOL_SLOTS);

	typedef struct packed {
		logic [INSTR_W-1:0] instr;
		logic [IDX_W-1:0]   next;
		logic [PRIO_W-1:0]  prio;
	} slot_entry_t;

	slot_entry_t slot_mem [POOL_SLOTS];
	slot_entry_t rd_q;

	// field write enables so a link can be patched without touching the number
	always_ff @(posedge clk) begin
		if (ctl.we_instr) begin
			slot_mem[waddr].instr <= wr_instr;
		end
		if (ctl.we_link) begin
			slot_mem[waddr].next <= wr_next;
			slot_mem[waddr].prio <= wr_prio;
		end
		if (ctl.re) begin
			rd_q <= slot_mem[raddr];
		end
	end

	assign rd_instr = rd_q.instr;
	assign rd_next  = rd_q.next;
	assign rd_prio  = rd_q.prio;

endmodule
